// ----- sv/cds_pkg.sv -----
// Shared widths, constants and calendar tables for the date stepper.
package cds_pkg;

    // Field widths.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YDAY_W  = 9;
    localparam int WDAY_W  = 3;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    // Century quotient of a 14-bit year is at most 163.
    localparam int CENT_W = 8;
    // Weekday congruence sum stays below 2^15.
    localparam int SUM_W  = 15;
    // Month term of the congruence, at most 38.
    localparam int ZTERM_W = 6;

    // Divide by 100 as a multiply by 5243 / 2^19, exact for 14-bit values.
    localparam int RECIP_100    = 5243;
    localparam int RECIP_100_W  = 13;
    localparam int RECIP_100_SH = 19;
    localparam int CENTURY      = 100;

    // Divide by 7 as a multiply by 9363 / 2^16. This is exact for values below
    // 13108; the weekday sum of a valid date is at most 12487.
    localparam int RECIP_7    = 9363;
    localparam int RECIP_7_W  = 14;
    localparam int RECIP_7_SH = 16;
    localparam int WEEK_LEN   = 7;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9998;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_DEC_LAST = 5'd31;

    // Length of a month; codes outside 1 to 12 give zero.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of a month in a common year.
    function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [YDAY_W-1:0] dsum;
        unique case (m)
            4'd1:    dsum = 9'd0;
            4'd2:    dsum = 9'd31;
            4'd3:    dsum = 9'd59;
            4'd4:    dsum = 9'd90;
            4'd5:    dsum = 9'd120;
            4'd6:    dsum = 9'd151;
            4'd7:    dsum = 9'd181;
            4'd8:    dsum = 9'd212;
            4'd9:    dsum = 9'd243;
            4'd10:   dsum = 9'd273;
            4'd11:   dsum = 9'd304;
            4'd12:   dsum = 9'd334;
            default: dsum = 9'd0;
        endcase
        return dsum;
    endfunction

    // Month term (13 * m + 8) / 5 with January and February as months 13 and 14.
    function automatic logic [ZTERM_W-1:0] zeller_term(input logic [MONTH_W-1:0] m);
        logic [ZTERM_W-1:0] t;
        unique case (m)
            4'd1:    t = 6'd35;
            4'd2:    t = 6'd38;
            4'd3:    t = 6'd9;
            4'd4:    t = 6'd12;
            4'd5:    t = 6'd14;
            4'd6:    t = 6'd17;
            4'd7:    t = 6'd19;
            4'd8:    t = 6'd22;
            4'd9:    t = 6'd25;
            4'd10:   t = 6'd27;
            4'd11:   t = 6'd30;
            4'd12:   t = 6'd32;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

// ----- sv/calendar_date_step_top.sv -----
// Gregorian date stepper: following and preceding date, ordinal day and weekday.
//
// One date enters per clock cycle while the output keeps taking results. Its result
// is presented on the output from the last register stage, r_out.
// The work runs through three register stages: the century split and leap-year
// decision, then the calendar step and weekday sum, then the modulo-7 reduction
// by reciprocal multiply. Each stage holds its request while the next one is
// full, so while a finished result waits on the output the block takes up to two
// more dates before it stops accepting. An invalid date gives bad_date in tuser
// and an all-zero tdata.
module calendar_date_step_top
    import cds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // year [13:0], month [17:14], day [22:18], zero [23]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // next_year [13:0], next_month [17:14], next_day [22:18], prev_year [36:23],
    // prev_month [40:37], prev_day [45:41], year_day [54:46], week_day [57:55],
    // zero [63:58]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // bad_date [0]
    output logic [0:0]             m_axis_tuser
);

    localparam int Q7_PROD_W = SUM_W + RECIP_7_W;
    localparam int Q7_W      = Q7_PROD_W - RECIP_7_SH;
    localparam int PAD_W     = OUT_TDATA_W - 2 * (YEAR_W + MONTH_W + DAY_W)
                               - YDAY_W - WDAY_W;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  zyear;
        logic [CENT_W-1:0]  zcent;
        logic               leap;
        logic               range_ok;
    } t_s1;

    typedef struct packed {
        logic [YEAR_W-1:0]  next_year;
        logic [MONTH_W-1:0] next_month;
        logic [DAY_W-1:0]   next_day;
        logic [YEAR_W-1:0]  prev_year;
        logic [MONTH_W-1:0] prev_month;
        logic [DAY_W-1:0]   prev_day;
        logic [YDAY_W-1:0]  year_day;
        logic [SUM_W-1:0]   wsum;
        logic               bad_date;
    } t_s2;

    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        logic [WDAY_W-1:0]  week_day;
        logic [YDAY_W-1:0]  year_day;
        logic [DAY_W-1:0]   prev_day;
        logic [MONTH_W-1:0] prev_month;
        logic [YEAR_W-1:0]  prev_year;
        logic [DAY_W-1:0]   next_day;
        logic [MONTH_W-1:0] next_month;
        logic [YEAR_W-1:0]  next_year;
    } t_out;

    logic r_s1_v, r_s2_v, r_s3_v;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_out r_out, n_out;
    logic r_bad, n_bad;

    logic s1_rdy, s2_rdy, s3_rdy;

    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic               early;
    logic [CENT_W-1:0]  y_cent;
    logic               y_rem_zero;
    logic               y_leap;

    logic [DAY_W-1:0]   mlen;
    logic [DAY_W-1:0]   prev_len;
    logic [MONTH_W-1:0] month_dn;
    logic               bad;

    logic [Q7_PROD_W-1:0] q7_prod;
    logic [Q7_W-1:0]      q7;
    logic [SUM_W-1:0]     q7_back;
    logic [SUM_W-1:0]     wrem;

    // Each stage advances when it is empty or its successor advances.
    assign s3_rdy        = !r_s3_v || m_axis_tready;
    assign s2_rdy        = !r_s2_v || s3_rdy;
    assign s1_rdy        = !r_s1_v || s2_rdy;
    assign s_axis_tready = s1_rdy;

    // Stage 1: unpack, century split, leap year and range checks.
    assign in_year  = s_axis_tdata[0 +: YEAR_W];
    assign in_month = s_axis_tdata[YEAR_W +: MONTH_W];
    assign in_day   = s_axis_tdata[YEAR_W + MONTH_W +: DAY_W];
    assign early    = (in_month <= MONTH_FEB);

    cds_cent_split u_cent_split (
        .i_year     (in_year),
        .o_cent     (y_cent),
        .o_rem_zero (y_rem_zero),
        .o_leap     (y_leap)
    );

    always_comb begin
        n_s1.year     = in_year;
        n_s1.month    = in_month;
        n_s1.day      = in_day;
        n_s1.leap     = y_leap;
        // January and February belong to the year before for the weekday.
        n_s1.zyear    = early ? (in_year - YEAR_MIN) : in_year;
        n_s1.zcent    = (early && y_rem_zero) ? (y_cent - CENT_W'(1)) : y_cent;
        n_s1.range_ok = (in_year >= YEAR_MIN) && (in_year <= YEAR_MAX) &&
                        (in_month >= MONTH_JAN) && (in_month <= MONTH_DEC) &&
                        (in_day >= DAY_FIRST);
    end

    // Stage 2: validity, date step in both directions, ordinal day, weekday sum.
    assign mlen     = month_days(r_s1.month, r_s1.leap);
    assign month_dn = r_s1.month - MONTH_JAN;
    assign prev_len = month_days(month_dn, r_s1.leap);
    assign bad      = !r_s1.range_ok || (r_s1.day > mlen);

    always_comb begin
        n_s2 = '0;
        n_s2.bad_date = bad;
        if (!bad) begin
            // Following day.
            if (r_s1.day < mlen) begin
                n_s2.next_year  = r_s1.year;
                n_s2.next_month = r_s1.month;
                n_s2.next_day   = r_s1.day + DAY_FIRST;
            end else if (r_s1.month == MONTH_DEC) begin
                n_s2.next_year  = r_s1.year + YEAR_MIN;
                n_s2.next_month = MONTH_JAN;
                n_s2.next_day   = DAY_FIRST;
            end else begin
                n_s2.next_year  = r_s1.year;
                n_s2.next_month = r_s1.month + MONTH_JAN;
                n_s2.next_day   = DAY_FIRST;
            end
            // Preceding day.
            if (r_s1.day > DAY_FIRST) begin
                n_s2.prev_year  = r_s1.year;
                n_s2.prev_month = r_s1.month;
                n_s2.prev_day   = r_s1.day - DAY_FIRST;
            end else if (r_s1.month == MONTH_JAN) begin
                n_s2.prev_year  = r_s1.year - YEAR_MIN;
                n_s2.prev_month = MONTH_DEC;
                n_s2.prev_day   = DAY_DEC_LAST;
            end else begin
                n_s2.prev_year  = r_s1.year;
                n_s2.prev_month = month_dn;
                n_s2.prev_day   = prev_len;
            end
            n_s2.year_day = days_before(r_s1.month) + YDAY_W'(r_s1.day) +
                            YDAY_W'((r_s1.month > MONTH_FEB) && r_s1.leap);
            n_s2.wsum = SUM_W'(r_s1.zyear) + SUM_W'(r_s1.zyear >> 2) -
                        SUM_W'(r_s1.zcent) + SUM_W'(r_s1.zcent >> 2) +
                        SUM_W'(zeller_term(r_s1.month)) + SUM_W'(r_s1.day);
        end
    end

    // Stage 3: weekday as the sum modulo 7, then pack the result.
    assign q7_prod = Q7_PROD_W'(r_s2.wsum) * Q7_PROD_W'(RECIP_7);
    assign q7      = q7_prod[RECIP_7_SH +: Q7_W];
    assign q7_back = SUM_W'(q7) * SUM_W'(WEEK_LEN);
    assign wrem    = r_s2.wsum - q7_back;

    always_comb begin
        n_out.pad        = '0;
        n_out.week_day   = wrem[WDAY_W-1:0];
        n_out.year_day   = r_s2.year_day;
        n_out.prev_day   = r_s2.prev_day;
        n_out.prev_month = r_s2.prev_month;
        n_out.prev_year  = r_s2.prev_year;
        n_out.next_day   = r_s2.next_day;
        n_out.next_month = r_s2.next_month;
        n_out.next_year  = r_s2.next_year;
        n_bad            = r_s2.bad_date;
    end

    // Valid bits travel with the requests.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_v <= s_axis_tvalid;
            end
            if (s2_rdy) begin
                r_s2_v <= r_s1_v;
            end
            if (s3_rdy) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    // Stage payloads load whenever their stage advances.
    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1 <= n_s1;
        end
        if (s2_rdy) begin
            r_s2 <= n_s2;
        end
        if (s3_rdy) begin
            r_out <= n_out;
            r_bad <= n_bad;
        end
    end

    assign m_axis_tvalid   = r_s3_v;
    assign m_axis_tdata    = r_out;
    assign m_axis_tuser[0] = r_bad;

`ifndef ASSERT_OFF
    // An invalid date carries an all-zero result.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("invalid date with nonzero result");

    // A valid date has a weekday below 7 and an ordinal day from 1 to 366.
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (m_axis_tdata[57:55] != 3'd7) && (m_axis_tdata[54:46] != 9'd0) &&
            (m_axis_tdata[54:46] <= 9'd366))
        else $error("weekday or ordinal day out of range");

    // A valid date never steps to a day numbered zero.
    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (m_axis_tdata[22:18] != 5'd0) && (m_axis_tdata[45:41] != 5'd0))
        else $error("stepped date has day zero");

    // An accepted request occupies the first stage.
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_s1_v)
        else $error("accepted request lost at stage one");
`endif

endmodule

// ----- sv/cds_cent_split.sv -----
// Century split of a year and the Gregorian leap-year decision.
module cds_cent_split
    import cds_pkg::*;
(
    input  logic [YEAR_W-1:0] i_year,
    output logic [CENT_W-1:0] o_cent,
    output logic              o_rem_zero,
    output logic              o_leap
);

    localparam int PROD_W = YEAR_W + RECIP_100_W;

    logic [PROD_W-1:0] prod;
    logic [YEAR_W-1:0] cent_back;
    logic [YEAR_W-1:0] rem;

    // Quotient by reciprocal multiply, remainder by subtracting it back.
    assign prod      = PROD_W'(i_year) * PROD_W'(RECIP_100);
    assign o_cent    = prod[RECIP_100_SH +: CENT_W];
    assign cent_back = YEAR_W'(o_cent) * YEAR_W'(CENTURY);
    assign rem       = i_year - cent_back;
    assign o_rem_zero = (rem == '0);

    // Divisible by 4 and not by 100, or divisible by 400.
    assign o_leap = ((i_year[1:0] == 2'b00) && !o_rem_zero) ||
                    (o_rem_zero && (o_cent[1:0] == 2'b00));

endmodule

// ----- tb/calendar_date_step_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the date stepper: directed edge dates, then random dates.
module calendar_date_step_top_test
    import cds_pkg::*;
();

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_DATES   = 1030;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 500;

    // One expected result, tagged with the date that produced it.
    typedef struct {
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
        logic [YEAR_W-1:0]  next_year;
        logic [MONTH_W-1:0] next_month;
        logic [DAY_W-1:0]   next_day;
        logic [YEAR_W-1:0]  prev_year;
        logic [MONTH_W-1:0] prev_month;
        logic [DAY_W-1:0]   prev_day;
        logic [YDAY_W-1:0]  year_day;
        logic [WDAY_W-1:0]  week_day;
        logic               bad_date;
    } t_date_step;

    // Calendar predictor and the queue of results still owed by the block.
    class t_date_scoreboard;
        t_date_step owed_q[$];
        int errors;

        function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // Length of month m (1 to 12) of year y.
        function int unsigned month_len(int unsigned y, int unsigned m);
            if (m == MONTH_FEB) begin
                return is_leap(y) ? 29 : 28;
            end
            case (m)
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function t_date_step step_date(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                       logic [DAY_W-1:0] d);
            t_date_step r;
            int unsigned len, yd, zy, zm, wd;
            r = '{default: '0};
            r.in_year  = y;
            r.in_month = m;
            r.in_day   = d;
            if (y < YEAR_MIN || y > YEAR_MAX || m < MONTH_JAN || m > MONTH_DEC ||
                d < DAY_FIRST || d > month_len(32'(y), 32'(m))) begin
                r.bad_date = 1'b1;
                return r;
            end
            len = month_len(32'(y), 32'(m));

            // Following day, rolling over month and year ends.
            if (d < len) begin
                r.next_year = y; r.next_month = m; r.next_day = d + DAY_FIRST;
            end else if (m == MONTH_DEC) begin
                r.next_year = y + YEAR_MIN; r.next_month = MONTH_JAN;
                r.next_day = DAY_FIRST;
            end else begin
                r.next_year = y; r.next_month = m + MONTH_JAN; r.next_day = DAY_FIRST;
            end

            // Preceding day; January first falls back to December 31 of the year before.
            if (d > DAY_FIRST) begin
                r.prev_year = y; r.prev_month = m; r.prev_day = d - DAY_FIRST;
            end else if (m == MONTH_JAN) begin
                r.prev_year = y - YEAR_MIN; r.prev_month = MONTH_DEC;
                r.prev_day = DAY_DEC_LAST;
            end else begin
                r.prev_year = y; r.prev_month = m - MONTH_JAN;
                r.prev_day = DAY_W'(month_len(32'(y), 32'(m - MONTH_JAN)));
            end

            // Ordinal day as the sum of the earlier month lengths.
            yd = 32'(d);
            for (int unsigned k = 1; k < m; k++) begin
                yd += month_len(32'(y), k);
            end
            r.year_day = YDAY_W'(yd);

            // Zeller congruence with January and February in the previous year.
            zy = 32'(y);
            zm = 32'(m);
            if (zm <= 2) begin
                zy = zy - 1;
                zm = zm + 12;
            end
            wd = (zy + zy / 4 - zy / 100 + zy / 400 + (13 * zm + 8) / 5 + 32'(d)) % 7;
            r.week_day = WDAY_W'(wd);
            return r;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void note_request(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                   logic [DAY_W-1:0] d);
            owed_q.push_back(step_date(y, m, d));
        endfunction

        task check_field(t_date_step want, string name, int unsigned got,
                         int unsigned exp_val);
            if (got != exp_val) begin
                report($sformatf("%0d-%0d-%0d %s got %0d want %0d", want.in_year,
                                 want.in_month, want.in_day, name, got, exp_val));
            end
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data, logic [0:0] user);
            t_date_step want;
            if (owed_q.size() == 0) begin
                report("result arrived with no request outstanding");
                return;
            end
            want = owed_q.pop_front();
            check_field(want, "next_year",  32'(data[13:0]),  32'(want.next_year));
            check_field(want, "next_month", 32'(data[17:14]), 32'(want.next_month));
            check_field(want, "next_day",   32'(data[22:18]), 32'(want.next_day));
            check_field(want, "prev_year",  32'(data[36:23]), 32'(want.prev_year));
            check_field(want, "prev_month", 32'(data[40:37]), 32'(want.prev_month));
            check_field(want, "prev_day",   32'(data[45:41]), 32'(want.prev_day));
            check_field(want, "year_day",   32'(data[54:46]), 32'(want.year_day));
            check_field(want, "week_day",   32'(data[57:55]), 32'(want.week_day));
            check_field(want, "padding",    32'(data[63:58]), 0);
            check_field(want, "bad_date",   32'(user),        32'(want.bad_date));
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    t_date_scoreboard sb = new();
    bit steady;
    int idle_cycles;

    calendar_date_step_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Mostly short gaps, now and then a long one; none during steady stretches.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Present one date and hold it until the block takes the request.
    task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, d, m, y};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Random date: mostly valid with month and year edges favored, the rest fully random or invalid.
    task automatic pick_date(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
                             output logic [DAY_W-1:0] d);
        int sel;
        int unsigned len;
        int unsigned edge_years[12] = '{1, 2, 9997, 9998, 1600, 1700, 1800, 1900,
                                        2000, 2100, 2400, 4000};
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            y = YEAR_W'($urandom_range(0, 16383));
            m = MONTH_W'($urandom_range(0, 15));
            d = DAY_W'($urandom_range(0, 31));
            return;
        end
        case ($urandom_range(0, 9))
            0:       y = YEAR_W'(edge_years[$urandom_range(0, 11)]);
            1:       y = YEAR_W'(4 * $urandom_range(1, 2499));
            2:       y = YEAR_W'(100 * $urandom_range(1, 99));
            default: y = YEAR_W'($urandom_range(YEAR_MIN, YEAR_MAX));
        endcase
        m = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
        len = sb.month_len(32'(y), 32'(m));
        case ($urandom_range(0, 9))
            0, 1:    d = DAY_FIRST;
            2, 3:    d = DAY_W'(len);
            4:       d = DAY_W'(len - 1);
            default: d = DAY_W'($urandom_range(1, len));
        endcase
        // Near-miss invalid dates: one field pushed outside its valid range.
        if (sel < 20) begin
            case ($urandom_range(0, 3))
                0: m = $urandom_range(0, 1) ? 4'd0 : MONTH_W'($urandom_range(13, 15));
                1: d = 5'd0;
                2: y = $urandom_range(0, 1) ? 14'd0 : YEAR_W'($urandom_range(9999, 16383));
                default: d = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : 5'd0;
            endcase
        end
    endtask

    // Output side: ready held low for random stretches, then high for a while.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
    end

    // Monitor: record accepted requests and check accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tdata[13:0], s_axis_tdata[17:14], s_axis_tdata[22:18]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial begin
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        steady        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed dates: range limits, leap rules and year boundaries.
        send_date(14'd1, 4'd1, 5'd1);
        send_date(14'd9998, 4'd12, 5'd31);
        send_date(14'd0, 4'd1, 5'd1);
        send_date(14'd9999, 4'd1, 5'd1);
        send_date(14'd16383, 4'd15, 5'd31);
        send_date(14'd0, 4'd0, 5'd0);
        send_date(14'd2000, 4'd0, 5'd10);
        send_date(14'd2000, 4'd13, 5'd1);
        send_date(14'd2000, 4'd6, 5'd0);
        send_date(14'd2001, 4'd4, 5'd31);
        send_date(14'd2000, 4'd2, 5'd29);
        send_date(14'd1900, 4'd2, 5'd29);
        send_date(14'd2024, 4'd2, 5'd29);
        send_date(14'd2023, 4'd2, 5'd29);
        send_date(14'd1900, 4'd2, 5'd28);
        send_date(14'd2000, 4'd3, 5'd1);
        send_date(14'd1900, 4'd3, 5'd1);
        send_date(14'd2023, 4'd12, 5'd31);
        send_date(14'd2024, 4'd1, 5'd1);
        send_date(14'd2024, 4'd12, 5'd31);
        send_date(14'd2100, 4'd3, 5'd1);
        send_date(14'd5000, 4'd8, 5'd31);
        send_date(14'd8191, 4'd7, 5'd15);
        drain_results();

        // Random dates, with back-to-back stretches and one full drain midway.
        for (int i = 0; i < RANDOM_DATES; i++) begin
            steady = (i >= 300 && i < 450) || (i >= 800 && i < 900);
            if (i == 600) begin
                drain_results();
            end
            pick_date(y, m, d);
            send_date(y, m, d);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        steady = 1'b0;

        // Wait for the last results, then run on to catch any stray output.
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/cds_pkg.sv
sv/cds_cent_split.sv
sv/calendar_date_step_top.sv
tb/calendar_date_step_top_test.sv
